// ===== hdl/mavg_pkg.sv =====
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared constants and controller/datapath interface types for the boxcar
// moving average filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mavg_pkg;

  // fixed field widths and defaults
  localparam int unsigned CFG_W           = 7;
  localparam int unsigned WINDOW_MAX_DEF  = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam logic [CFG_W-1:0] WIN_RESET  = 7'd8;

  // controller to datapath
  typedef struct packed {
    logic capture;   // take sample, decide eviction, start ring read
    logic update;    // update sum, count, slot and write ring
    logic div_load;  // load divider with |sum|, held count as divisor
    logic div_step;  // one restoring division step
    logic out_load;  // load output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;  // current step is the final one
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/mavg_ram.sv =====
// ----------------------------------------------------------------------------
// mavg_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                           wdata_i,
  input  wire logic                                       re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/mavg_ctrl.sv =====
// ----------------------------------------------------------------------------
// mavg_ctrl
// Sequencer for one sample: capture, update, divider load, division steps,
// hand-off to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_ctrl
  import mavg_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        state_d      = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== hdl/mavg_dp.sv =====
// ----------------------------------------------------------------------------
// mavg_dp
// Datapath: sample ring, running sum, held count, write slot, restoring
// divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_dp
  import mavg_pkg::*;
#(
  parameter int unsigned WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned HELD_W      = $clog2(WINDOW_MAX + 1)
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire cmd_t                   cmd_i,
  output sts_t                        sts_o,
  input  wire logic [CFG_W-1:0]       win_len_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  output logic      [SAMPLE_BITS-1:0] average_o,
  output logic      [HELD_W-1:0]      held_o
);

  localparam int unsigned SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int unsigned CMP_W  = (HELD_W > CFG_W) ? HELD_W : CFG_W;
  localparam int unsigned CNT_W  = $clog2(SUM_W);

  logic [SAMPLE_BITS-1:0] sample_q;
  logic                   evict_q;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [HELD_W-1:0]      held_q, held_d;
  logic [SLOT_W-1:0]      slot_q, slot_d;
  logic [HELD_W-1:0]      rem_q;
  logic [SUM_W-1:0]       quo_q;
  logic                   neg_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [SAMPLE_BITS-1:0] avg_q;
  logic [HELD_W-1:0]      held_out_q;

  logic [CMP_W-1:0]       win_ext, win_eff;
  logic [HELD_W-1:0]      h_mod, slot_ext, oldest_ext, held_dec;
  logic [SLOT_W-1:0]      oldest;
  logic                   evict;
  logic [SAMPLE_BITS-1:0] ring_rdata;
  logic [SUM_W-1:0]       old_ext, new_ext;
  logic [HELD_W:0]        rem_sh, rem_sub;
  logic                   ge;
  logic [SUM_W-1:0]       quo_signed;

  // clamp window length to 1 .. WINDOW_MAX
  always_comb begin
    win_ext = CMP_W'(win_len_i);
    if (win_ext == '0) begin
      win_eff = CMP_W'(1);
    end else if (win_ext > CMP_W'(WINDOW_MAX)) begin
      win_eff = CMP_W'(WINDOW_MAX);
    end else begin
      win_eff = win_ext;
    end
  end

  assign evict = (CMP_W'(held_q) >= win_eff) && (held_q != '0);

  // oldest slot is write slot minus held count, modulo the ring depth
  assign h_mod    = (held_q == HELD_W'(WINDOW_MAX)) ? '0 : held_q;
  assign slot_ext = HELD_W'(slot_q);
  always_comb begin
    if (slot_ext >= h_mod) begin
      oldest_ext = slot_ext - h_mod;
    end else begin
      oldest_ext = slot_ext + HELD_W'(WINDOW_MAX) - h_mod;
    end
  end
  assign oldest = oldest_ext[SLOT_W-1:0];

  mavg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (slot_q),
    .wdata_i (sample_q),
    .re_i    (cmd_i.capture),
    .raddr_i (oldest),
    .rdata_o (ring_rdata)
  );

  // window update
  assign old_ext  = evict_q ? SUM_W'($signed(ring_rdata)) : '0;
  assign new_ext  = SUM_W'($signed(sample_q));
  assign held_dec = evict_q ? (held_q - HELD_W'(1)) : held_q;

  always_comb begin
    sum_d  = sum_q;
    held_d = held_q;
    slot_d = slot_q;
    if (cmd_i.update) begin
      sum_d  = sum_q - old_ext + new_ext;
      held_d = (held_dec < HELD_W'(WINDOW_MAX)) ? (held_dec + HELD_W'(1)) : held_dec;
      slot_d = (slot_q == SLOT_W'(WINDOW_MAX - 1)) ? '0 : (slot_q + SLOT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      held_q <= '0;
      slot_q <= '0;
    end else begin
      sum_q  <= sum_d;
      held_q <= held_d;
      slot_q <= slot_d;
    end
  end

  // restoring division of |sum| by held count, one quotient bit per step
  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, held_q});
  assign rem_sub = rem_sh - {1'b0, held_q};

  assign quo_signed = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sample_q <= sample_i;
      evict_q  <= evict;
    end
    if (cmd_i.div_load) begin
      neg_q <= sum_q[SUM_W-1];
      quo_q <= sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;
      rem_q <= '0;
      cnt_q <= CNT_W'(SUM_W - 1);
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? rem_sub[HELD_W-1:0] : rem_sh[HELD_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], ge};
      cnt_q <= cnt_q - CNT_W'(1);
    end
    if (cmd_i.out_load) begin
      avg_q      <= quo_signed[SAMPLE_BITS-1:0];
      held_out_q <= held_q;
    end
  end

  assign sts_o.div_last = (cnt_q == '0);
  assign average_o      = avg_q;
  assign held_o         = held_out_q;

endmodule

`default_nettype wire

// ===== hdl/moving_average_filter_core.sv =====
// ----------------------------------------------------------------------------
// moving_average_filter_core
// Boxcar moving average: ring of recent samples, running sum and count,
// mean truncated toward zero through a bit-serial divider.
// ----------------------------------------------------------------------------
//
// channel  direction  handshake               payload
// s_axis   in         tvalid/tready           tdata: sample
// m_axis   out        tvalid/tready           tdata: average, samples_held
// cfg      in         cfg_valid/cfg_ready     cfg_data: window_length
//
// an accepted sample goes through the update and divider load states, then
// the restoring divider, one quotient bit per cycle over the running sum
// width, and its mean is loaded into the output register once that is free
// the next sample can be taken once the result sits in the output register;
// no new sample is accepted while one is still in progress
// reset clears sum, count, write slot and handshake state; window length
// returns to 8, ring contents are left as they are
// a stalled output holds its transaction and the finished item waits in the
// controller until the output register frees up
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_filter_core
  import mavg_pkg::*;
#(
  parameter int unsigned WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned HELD_W      = $clog2(WINDOW_MAX + 1),
  parameter int unsigned IN_W        = ((SAMPLE_BITS + 7) / 8) * 8,
  parameter int unsigned OUT_W       = ((SAMPLE_BITS + HELD_W + 7) / 8) * 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // input sample stream
  input  wire logic             s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  wire logic [IN_W-1:0]  s_axis_tdata_i,   // sample
  // result stream
  output logic                  m_axis_tvalid_o,
  input  wire logic             m_axis_tready_i,
  output logic      [OUT_W-1:0] m_axis_tdata_o,   // average, samples_held, zero pad
  // window length register
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CFG_W-1:0] cfg_data_i        // window_length
);

  cmd_t                   cmd;
  sts_t                   sts;
  logic [CFG_W-1:0]       win_len_q, win_len_d;
  logic [SAMPLE_BITS-1:0] average;
  logic [HELD_W-1:0]      held;

  // window length register, always writable
  assign cfg_ready_o = 1'b1;
  assign win_len_d   = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : win_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= WIN_RESET;
    end else begin
      win_len_q <= win_len_d;
    end
  end

  // sequencer
  mavg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // ring, sum, count and divider
  mavg_dp #(
    .WINDOW_MAX  (WINDOW_MAX),
    .SAMPLE_BITS (SAMPLE_BITS),
    .HELD_W      (HELD_W)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .win_len_i (win_len_q),
    .sample_i  (s_axis_tdata_i[SAMPLE_BITS-1:0]),
    .average_o (average),
    .held_o    (held)
  );

  // average in the low bits, then the held count, zero padded to bytes
  assign m_axis_tdata_o = OUT_W'({held, average});

  // a result always reports at least one and at most WINDOW_MAX samples
  a_held_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (held != '0) && (held <= HELD_W'(WINDOW_MAX)))
    else $error("samples_held out of range");

  // no sample is taken while the divider is running
  a_busy_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_step |-> !s_axis_tready_o)
    else $error("input ready during division");

  // an accepted sample never reaches the output register in the next cycle
  a_min_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !cmd.out_load && !cmd.div_step)
    else $error("result loaded too early");

endmodule

`default_nettype wire

// ===== tb/tb_moving_average_filter_core.sv =====
// ----------------------------------------------------------------------------
// tb_moving_average_filter_core
// Self-checking bench for the boxcar moving average: a sample table, partly with
// hand-worked means, then randomised phases under changing window lengths; the
// other output transactions are checked against a local model of ring, sum and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_moving_average_filter_core
  import mavg_pkg::*;
;

  localparam int unsigned WIN_MAX      = 64;
  localparam int unsigned IN_W         = 16;
  localparam int unsigned OUT_W        = 24;
  localparam int unsigned SETTLE_CYCLES = 40;   // settle time after the last mean has come back
  localparam int unsigned PHASES       = 12;
  localparam int unsigned PHASE_ITEMS  = 152;
  localparam int unsigned HOLD_AT      = 1300;  // random item that triggers the long stall
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned EXP_DEPTH    = 4096;

  // one expected result: average and samples held, in tdata at [15:0] and [22:16]
  typedef struct packed {
    logic signed [15:0] average;
    logic [6:0]         held;
  } mean_t;

  typedef struct packed {
    bit                 set_win;   // write the window before this sample
    logic [CFG_W-1:0]   win;
    logic signed [15:0] sample;
    bit                 typed;     // expected mean written out by hand
    logic signed [15:0] avg;
    logic [6:0]         held;
  } directed_row_t;

  localparam int unsigned DIR_ROWS = 22;

  // window starts at its reset value of 8
  localparam directed_row_t DIRECTED_SAMPLES [DIR_ROWS] = '{
    '{1'b0, 7'd0,   16'sh7FFF,  1'b1, 16'sh7FFF,    7'd1},
    '{1'b0, 7'd0,   16'sh7FFF,  1'b1, 16'sh7FFF,    7'd2},
    '{1'b0, 7'd0,   16'sh8000,  1'b1, 16'sd10922,   7'd3},
    '{1'b0, 7'd0,   16'sh8000,  1'b1, 16'sd0,       7'd4},  // -2/4 truncates to zero
    '{1'b0, 7'd0,   16'sh8000,  1'b1, -16'sd6554,   7'd5},
    '{1'b0, 7'd0,   16'sd0,     1'b1, -16'sd5461,   7'd6},
    '{1'b0, 7'd0,   -16'sd1,    1'b1, -16'sd4681,   7'd7},
    '{1'b0, 7'd0,   16'sd1,     1'b1, -16'sd4096,   7'd8},
    '{1'b0, 7'd0,   16'sh8000,  1'b0, 16'sd0,       7'd0},  // window full, oldest evicted
    '{1'b0, 7'd0,   16'sh7FFF,  1'b0, 16'sd0,       7'd0},
    '{1'b1, 7'd0,   16'sd100,   1'b0, 16'sd0,       7'd0},  // zero window acts as one
    '{1'b0, 7'd0,   -16'sd100,  1'b0, 16'sd0,       7'd0},
    '{1'b1, 7'd1,   16'sd5,     1'b0, 16'sd0,       7'd0},
    '{1'b1, 7'd127, 16'sh7FFF,  1'b0, 16'sd0,       7'd0},  // saturates to the maximum
    '{1'b0, 7'd0,   16'sh8000,  1'b0, 16'sd0,       7'd0},
    '{1'b1, 7'd64,  16'sd12345, 1'b0, 16'sd0,       7'd0},
    '{1'b1, 7'd3,   -16'sd7,    1'b0, 16'sd0,       7'd0},  // shrunk, count must not fall
    '{1'b0, 7'd0,   16'sd7,     1'b0, 16'sd0,       7'd0},
    '{1'b1, 7'd12,  16'sh7FFF,  1'b0, 16'sd0,       7'd0},  // grown again, count climbs
    '{1'b0, 7'd0,   16'sh8000,  1'b0, 16'sd0,       7'd0},
    '{1'b0, 7'd0,   16'sh5555,  1'b0, 16'sd0,       7'd0},
    '{1'b0, 7'd0,   16'shAAAA,  1'b0, 16'sd0,       7'd0}
  };

  // windows for the first random phases, the rest are drawn
  localparam logic [CFG_W-1:0] EARLY_WINDOWS [8] = '{
    7'd2, 7'd5, 7'd0, 7'd1, 7'd20, 7'd64, 7'd127, 7'd3
  };

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             s_tvalid   = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata    = '0;
  logic             m_tvalid;
  logic             m_tready   = 1'b0;
  logic [OUT_W-1:0] m_tdata;
  logic             cfg_valid  = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data   = '0;

  // model state
  logic signed [15:0] history [WIN_MAX];
  logic [5:0]         next_slot;
  logic [6:0]         fill_count;
  logic signed [21:0] window_sum;
  logic [CFG_W-1:0]   window_reg;

  // expected means in order, written by the sender and read by the checker
  mean_t       expected_means [EXP_DEPTH];
  logic [11:0] exp_wr_ptr     = '0;
  logic [11:0] exp_rd_ptr     = '0;
  int unsigned mismatch_count = 0;
  int unsigned tx_idle_pct    = 14;
  int unsigned rx_idle_pct    = 65;
  bit          hold_request   = 1'b0;

  moving_average_filter_core DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // push one sample into the window and return the mean the block owes for it
  function automatic mean_t predict_average(input logic signed [15:0] s);
    int unsigned win;
    int unsigned oldest;
    longint      quot;
    mean_t       r;
    win = window_reg;
    if (win < 1) win = 1;
    if (win > WIN_MAX) win = WIN_MAX;
    // full window: drop the oldest sample, at most one per new sample
    if (fill_count >= win && fill_count > 0) begin
      oldest = (int'(next_slot) + WIN_MAX - (int'(fill_count) % WIN_MAX)) % WIN_MAX;
      window_sum = window_sum - history[oldest];
      fill_count = fill_count - 7'd1;
    end
    history[next_slot] = s;
    window_sum = window_sum + s;
    if (fill_count < WIN_MAX) fill_count = fill_count + 7'd1;
    next_slot = next_slot + 6'd1;
    // longint division truncates toward zero
    quot = longint'(window_sum) / longint'(fill_count);
    r.average = quot[15:0];
    r.held    = fill_count;
    return r;
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'($urandom_range(16) - 8);
      3:       return ($urandom_range(1) != 0) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_window();
    case ($urandom_range(9))
      0:       return CFG_W'($urandom_range(127, 65));
      1:       return 7'd0;
      default: return CFG_W'($urandom_range(64, 1));
    endcase
  endfunction

  // lower valid and let every outstanding mean come back; called at a falling edge
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (exp_wr_ptr != exp_rd_ptr) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_window(input logic [CFG_W-1:0] w);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    window_reg = w;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // offer one sample; valid stays high on return unless the next call idles
  task automatic offer_sample(input logic [15:0] s, input bit typed, input mean_t typed_mean);
    mean_t predicted;
    if ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= s;
    do @(posedge clk); while (!s_tready);
    predicted = predict_average(s);
    expected_means[exp_wr_ptr] = typed ? typed_mean : predicted;
    exp_wr_ptr = exp_wr_ptr + 12'd1;
    @(negedge clk);
  endtask

  // result side: random tready, plus one long hold-off counted here
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // compare every output transaction with the oldest expected mean
  always @(posedge clk) begin : check_means
    mean_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (exp_wr_ptr == exp_rd_ptr) begin
        $error("unexpected result transaction: tdata %h", m_tdata);
        mismatch_count++;
      end else begin
        want       = expected_means[exp_rd_ptr];
        exp_rd_ptr = exp_rd_ptr + 12'd1;
        if (m_tdata[15:0] !== want.average) begin
          $error("average: expected %0d, got %0d", want.average, $signed(m_tdata[15:0]));
          mismatch_count++;
        end
        if (m_tdata[22:16] !== want.held) begin
          $error("samples_held: expected %0d, got %0d", want.held, m_tdata[22:16]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    mean_t       typed_mean;
    int unsigned item;
    item       = 0;
    next_slot  = '0;
    fill_count = '0;
    window_sum = '0;
    window_reg = WIN_RESET;

    // reset held low at start, then released away from the clock edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (int unsigned r = 0; r < DIR_ROWS; r++) begin
      if (DIRECTED_SAMPLES[r].set_win) write_window(DIRECTED_SAMPLES[r].win);
      typed_mean.average = DIRECTED_SAMPLES[r].avg;
      typed_mean.held    = DIRECTED_SAMPLES[r].held;
      offer_sample(DIRECTED_SAMPLES[r].sample, DIRECTED_SAMPLES[r].typed, typed_mean);
    end

    // random phases, each under its own window length
    for (int unsigned p = 0; p < PHASES; p++) begin
      write_window((p < 8) ? EARLY_WINDOWS[p] : pick_window());
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        // slow receiver first, then slow sender, then no idling at all
        if (item < PHASES * PHASE_ITEMS / 3) begin
          tx_idle_pct = 14;
          rx_idle_pct = 65;
        end else if (item < 2 * PHASES * PHASE_ITEMS / 3) begin
          tx_idle_pct = 65;
          rx_idle_pct = 14;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        if (item == HOLD_AT) hold_request = 1'b1;
        offer_sample(pick_sample(), 1'b0, '0);
        item++;
      end
    end

    wait_idle();
    if (mismatch_count == 0 && exp_wr_ptr == exp_rd_ptr) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
